@@ sv/tcc_pkg.sv @@
// Shared types and constants of the text console block.
package tcc_pkg;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int RCOL_W   = 7;
   localparam int RROW_W   = 5;
   localparam int OCOL_W   = 7;
   localparam int OROW_W   = 5;
   localparam int LIN_W    = 11;
   localparam int COLOR_W  = 8;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd10;

   // write-port source when no copy or print is pending
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_ZERO  = 2'd1;
   localparam logic [1:0] WR_BLANK = 2'd2;
   localparam logic [1:0] WR_FILL  = 2'd3;

   typedef struct packed {
      logic       latch;
      logic       newline;
      logic       ret;
      logic       tab_load;
      logic       print;
      logic       home;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       copy_rd;
      logic       cell_load;
      logic       load_rsp;
      logic [1:0] wr_sel;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                is_newline;
      logic                is_return;
      logic                last_col;
      logic                last_row;
      logic                tab_zero;
      logic                tab_one;
      logic                cnt_last;
      logic                copy_last;
   } status_type;

endpackage

@@ sv/tcc_if.sv @@
// Handshake channels of the text console: request, response and register write.
interface tcc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcc_pkg::OPCODE_W-1:0]  opcode;
   logic [tcc_pkg::CHAR_W-1:0]    char_code;
   logic [tcc_pkg::RCOL_W-1:0]    read_col;
   logic [tcc_pkg::RROW_W-1:0]    read_row;

   modport source (output valid, opcode, char_code, read_col, read_row, input ready);
   modport sink   (input valid, opcode, char_code, read_col, read_row, output ready);
endinterface

interface tcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcc_pkg::OCOL_W-1:0]    cursor_col;
   logic [tcc_pkg::OROW_W-1:0]    cursor_row;
   logic [tcc_pkg::LIN_W-1:0]     cursor_linear;
   logic [tcc_pkg::CHAR_W-1:0]    cell_char;
   logic [tcc_pkg::COLOR_W-1:0]   cell_color;

   modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_color,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_color,
                   output ready);
endinterface

interface tcc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tcc_pkg::COLOR_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ sv/text_console_cursor_scroll.sv @@
// A printed char or read steps through dispatch, print or capture, and finish to its response
// beat; newline (without a scroll), return or no-op go from dispatch to finish. A tab prints
// one space per step through the single write port. A scroll copies rows at one cell per cycle,
// then fills the bottom row; clear blanks the store at one character byte per cycle.
// One request in flight; the next is taken while the previous response waits.
// Reset: cursor homed, color 10; store zeroed before first accept.
module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcc_req_if.sink    req_if,
   tcc_rsp_if.source  rsp_if,
   tcc_csr_if.sink    csr_if
);

   tcc_pkg::cmd_type    cmd;
   tcc_pkg::status_type st;

   assign csr_if.ready = 1'b1;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .st        (st),
      .cmd       (cmd)
   );

   tcc_dpath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .opcode        (req_if.opcode),
      .char_code     (req_if.char_code),
      .read_col      (req_if.read_col),
      .read_row      (req_if.read_row),
      .csr_we        (csr_if.valid && csr_if.ready),
      .csr_data      (csr_if.data),
      .cursor_col    (rsp_if.cursor_col),
      .cursor_row    (rsp_if.cursor_row),
      .cursor_linear (rsp_if.cursor_linear),
      .cell_char     (rsp_if.cell_char),
      .cell_color    (rsp_if.cell_color)
   );

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while another is in flight");

   // a scroll copy write owns the next cycle's write port
   a_copy_port: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_rd |=> !cmd.print && (cmd.wr_sel == tcc_pkg::WR_NONE))
      else $error("write port conflict after scroll copy read");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (32'(rsp_if.cursor_col) < 32'(COLUMNS)))
      else $error("reported cursor column out of range");

endmodule

@@ sv/tcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tcc_ctrl.sv @@
// Controller state machine of the text console.
module tcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  tcc_pkg::status_type st,
   output tcc_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_PRINT    = 4'd3;
   localparam logic [3:0] S_SCROLL   = 4'd4;
   localparam logic [3:0] S_DRAIN    = 4'd5;
   localparam logic [3:0] S_FILL     = 4'd6;
   localparam logic [3:0] S_CLEAR    = 4'd7;
   localparam logic [3:0] S_CAPTURE  = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_sel = tcc_pkg::WR_NONE;
      unique case (state_ff)
         S_INIT: begin
            cmd.wr_sel = tcc_pkg::WR_ZERO;
            if (st.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.op)
               tcc_pkg::OP_PUT: begin
                  if (st.is_newline) begin
                     cmd.newline = 1'b1;
                     if (st.last_row) begin
                        cmd.cnt_clr = 1'b1;
                        state_in    = S_SCROLL;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end else if (st.is_return) begin
                     cmd.ret  = 1'b1;
                     state_in = S_FINISH;
                  end else begin
                     cmd.tab_load = 1'b1;
                     state_in     = S_PRINT;
                  end
               end
               tcc_pkg::OP_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_CLEAR;
               end
               tcc_pkg::OP_READ: state_in = S_CAPTURE;
               default:          state_in = S_FINISH;
            endcase
         end
         S_PRINT: begin
            cmd.print = 1'b1;
            if (st.last_col && st.last_row) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_SCROLL;
            end else if (st.tab_one) begin
               state_in = S_FINISH;
            end
         end
         S_SCROLL: begin
            cmd.copy_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (st.copy_last) begin
               state_in = S_DRAIN;
            end
         end
         // last copy write lands here; counter already points at the bottom row
         S_DRAIN: state_in = S_FILL;
         S_FILL: begin
            cmd.wr_sel = tcc_pkg::WR_FILL;
            if (st.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = st.tab_zero ? S_FINISH : S_PRINT;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.wr_sel = tcc_pkg::WR_BLANK;
            if (st.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               cmd.home    = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_CAPTURE: begin
            cmd.cell_load = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/tcc_dpath.sv @@
// Datapath of the text console: cursor, screen store, sweep counter, result register.
module tcc_dpath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcc_pkg::cmd_type                cmd,
   output tcc_pkg::status_type             st,
   input  logic [tcc_pkg::OPCODE_W-1:0]    opcode,
   input  logic [tcc_pkg::CHAR_W-1:0]      char_code,
   input  logic [tcc_pkg::RCOL_W-1:0]      read_col,
   input  logic [tcc_pkg::RROW_W-1:0]      read_row,
   input  logic                            csr_we,
   input  logic [tcc_pkg::COLOR_W-1:0]     csr_data,
   output logic [tcc_pkg::OCOL_W-1:0]      cursor_col,
   output logic [tcc_pkg::OROW_W-1:0]      cursor_row,
   output logic [tcc_pkg::LIN_W-1:0]       cursor_linear,
   output logic [tcc_pkg::CHAR_W-1:0]      cell_char,
   output logic [tcc_pkg::COLOR_W-1:0]     cell_color
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   logic [tcc_pkg::OPCODE_W-1:0] op_ff;
   logic [tcc_pkg::CHAR_W-1:0]   char_ff;
   logic [tcc_pkg::RCOL_W-1:0]   rcol_ff;
   logic [tcc_pkg::RROW_W-1:0]   rrow_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [2:0]    tab_ff, tab_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          copy_pend_ff;
   logic [AW-1:0] copy_dst_ff;
   logic [tcc_pkg::COLOR_W-1:0] color_ff;

   logic [tcc_pkg::CHAR_W-1:0]  cell_char_ff;
   logic [tcc_pkg::COLOR_W-1:0] cell_color_ff;

   logic [tcc_pkg::OCOL_W-1:0]  rsp_col_ff;
   logic [tcc_pkg::OROW_W-1:0]  rsp_row_ff;
   logic [tcc_pkg::LIN_W-1:0]   rsp_lin_ff;
   logic [tcc_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic [tcc_pkg::COLOR_W-1:0] rsp_color_ff;

   logic          is_tab, last_col, last_row, in_range;
   logic [AW-1:0] cur_lin, cell_addr, rd_addr, wr_addr;
   logic          char_we, color_we;
   logic [tcc_pkg::CHAR_W-1:0]  wr_char, rd_char;
   logic [tcc_pkg::COLOR_W-1:0] wr_color, rd_color;

   assign is_tab   = (char_ff == tcc_pkg::CH_TAB);
   assign last_col = (col_ff == CW'(COLUMNS - 1));
   assign last_row = (row_ff == RW'(ROWS - 1));
   assign in_range = (32'(rcol_ff) < 32'(COLUMNS)) && (32'(rrow_ff) < 32'(ROWS));
   assign cur_lin   = AW'(AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff));
   assign cell_addr = AW'(AW'(rrow_ff) * AW'(COLUMNS) + AW'(rcol_ff));
   assign rd_addr   = cmd.copy_rd ? AW'(cnt_ff + AW'(COLUMNS)) : cell_addr;

   always_comb begin
      st.op         = op_ff;
      st.is_newline = (char_ff == tcc_pkg::CH_NEWLINE);
      st.is_return  = (char_ff == tcc_pkg::CH_RETURN);
      st.last_col   = last_col;
      st.last_row   = last_row;
      st.tab_zero   = (tab_ff == 3'd0);
      st.tab_one    = (tab_ff == 3'd1);
      st.cnt_last   = (cnt_ff == AW'(CELLS - 1));
      st.copy_last  = (cnt_ff == AW'(CELLS - COLUMNS - 1));
   end

   // cursor and tab count
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      tab_in = tab_ff;
      if (cmd.home) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.newline) begin
         col_in = '0;
         tab_in = 3'd0;
         if (!last_row) begin
            row_in = row_ff + RW'(1);
         end
      end else if (cmd.ret) begin
         col_in = '0;
      end else if (cmd.print) begin
         tab_in = tab_ff - 3'd1;
         if (last_col) begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (cmd.tab_load) begin
         tab_in = is_tab ? 3'(3'd4 - {1'b0, col_ff[1:0]}) : 3'd1;
      end
   end

   always_comb begin
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + AW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // one write port: pending scroll copy, then print, then sweep writes
   always_comb begin
      wr_addr  = cnt_ff;
      char_we  = 1'b0;
      color_we = 1'b0;
      wr_char  = tcc_pkg::CH_SPACE;
      wr_color = color_ff;
      if (copy_pend_ff) begin
         wr_addr  = copy_dst_ff;
         char_we  = 1'b1;
         color_we = 1'b1;
         wr_char  = rd_char;
         wr_color = rd_color;
      end else if (cmd.print) begin
         wr_addr  = cur_lin;
         char_we  = 1'b1;
         color_we = 1'b1;
         wr_char  = is_tab ? tcc_pkg::CH_SPACE : char_ff;
      end else begin
         unique case (cmd.wr_sel)
            tcc_pkg::WR_ZERO: begin
               char_we  = 1'b1;
               color_we = 1'b1;
               wr_char  = '0;
               wr_color = '0;
            end
            tcc_pkg::WR_BLANK: char_we = 1'b1;
            tcc_pkg::WR_FILL: begin
               char_we  = 1'b1;
               color_we = 1'b1;
            end
            default: begin
               char_we  = 1'b0;
               color_we = 1'b0;
            end
         endcase
      end
   end

   tcc_ram #(.WIDTH(tcc_pkg::CHAR_W), .DEPTH(CELLS)) u_char_ram (
      .clock   (clock),
      .we      (char_we),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_addr),
      .rd_data (rd_char)
   );

   tcc_ram #(.WIDTH(tcc_pkg::COLOR_W), .DEPTH(CELLS)) u_color_ram (
      .clock   (clock),
      .we      (color_we),
      .wr_addr (wr_addr),
      .wr_data (wr_color),
      .rd_addr (rd_addr),
      .rd_data (rd_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         tab_ff       <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         color_ff     <= tcc_pkg::TEXT_COLOR_RESET;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         tab_ff       <= tab_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= cmd.copy_rd;
         if (csr_we) begin
            color_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= cnt_ff;
      if (cmd.latch) begin
         op_ff         <= opcode;
         char_ff       <= char_code;
         rcol_ff       <= read_col;
         rrow_ff       <= read_row;
         cell_char_ff  <= '0;
         cell_color_ff <= '0;
      end else if (cmd.cell_load) begin
         cell_char_ff  <= in_range ? rd_char : '0;
         cell_color_ff <= in_range ? rd_color : '0;
      end
      if (cmd.load_rsp) begin
         rsp_col_ff   <= tcc_pkg::OCOL_W'(col_ff);
         rsp_row_ff   <= tcc_pkg::OROW_W'(row_ff);
         rsp_lin_ff   <= tcc_pkg::LIN_W'(cur_lin);
         rsp_char_ff  <= cell_char_ff;
         rsp_color_ff <= cell_color_ff;
      end
   end

   assign cursor_col    = rsp_col_ff;
   assign cursor_row    = rsp_row_ff;
   assign cursor_linear = rsp_lin_ff;
   assign cell_char     = rsp_char_ff;
   assign cell_color    = rsp_color_ff;

endmodule
